// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the RTL files; the tag parser includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/tzsp_pkg.sv -----
package tzsp_pkg;

    localparam int unsigned MAX_PACKET_BYTES = 65535;
    localparam logic [7:0] TZSP_VERSION = 8'd1;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_END_TAG = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_TAG = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LEN_TAG = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STAMP32_TAG = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEVAL_TAG = 3'd4;

    localparam logic [7:0] RST_END_TAG = 8'd1;
    localparam logic [7:0] RST_PAD_TAG = 8'd0;
    localparam logic [7:0] RST_FRAME_LEN_TAG = 8'd41;
    localparam logic [7:0] RST_STAMP32_TAG = 8'd13;
    localparam logic [7:0] RST_TIMEVAL_TAG = 8'd255;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_BAD_VER = 2'd2,
        ST_NO_END  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SK_NONE    = 2'd0,
        SK_STAMP32 = 2'd1,
        SK_TIMEVAL = 2'd2
    } t_stamp_kind;

    localparam int unsigned FLAG_FRAME = 0;
    localparam int unsigned FLAG_STAMP32 = 1;
    localparam int unsigned FLAG_TIMEVAL = 2;

    typedef struct packed {
        t_status     status;
        logic [15:0] encap;
        logic [15:0] wire_length;
        logic        wire_len_tagged;
        t_stamp_kind stamp_kind;
        logic [31:0] stamp_sec;
        logic [31:0] stamp_usec;
        logic [15:0] payload_offset;
    } t_result;

endpackage

// ----- rtl/core/tzsp_in_if.sv -----
interface tzsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink (input valid, input data_byte, input last, output ready);
endinterface

// ----- rtl/core/tzsp_out_if.sv -----
interface tzsp_out_if;
    logic                   valid;
    logic                   ready;
    logic [1:0]             status;
    logic [15:0]            encap;
    logic [15:0]            wire_length;
    logic                   wire_len_tagged;
    logic [1:0]             stamp_kind;
    logic [31:0]            stamp_sec;
    logic [31:0]            stamp_usec;
    logic [15:0]            payload_offset;

    modport source (
        output valid, output status, output encap, output wire_length,
        output wire_len_tagged, output stamp_kind, output stamp_sec,
        output stamp_usec, output payload_offset, input ready
    );
    modport sink (
        input valid, input status, input encap, input wire_length,
        input wire_len_tagged, input stamp_kind, input stamp_sec,
        input stamp_usec, input payload_offset, output ready
    );
endinterface

// ----- rtl/core/tzsp_tag_parser.sv -----
// TZSP header and tag parser.
// The input channel carries one packet byte per beat, with last set on the
// final byte. The output channel carries one summary beat per packet:
// status, encapsulation, wire length, timestamp and payload offset.
// Tag codes are set through the write port and may only change while no
// packet is in flight.
// Throughput is one byte per cycle unless a full output register stalls
// the input. The parse state is updated in the cycle a byte is accepted,
// and the summary enters the output register in the cycle after its last byte.
// A single output register holds the summary. While it is full and the
// receiver stalls, the input stops accepting bytes; when the receiver takes
// the summary in the same cycle, a new byte is accepted at once.
// Reset clears the parse state and the output valid flag and restores the
// default tag codes. After each last byte the parse state returns to the
// header phase, ready for the next packet.
`include "assert_macros.svh"

module tzsp_tag_parser #(
    parameter int unsigned MAX_PACKET_BYTES = tzsp_pkg::MAX_PACKET_BYTES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tzsp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tzsp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tzsp_in_if.sink                         i_in,
    tzsp_out_if.source                      o_out
);

    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_TYPE   = 6'b000010,
        PH_LEN    = 6'b000100,
        PH_VALUE  = 6'b001000,
        PH_DONE   = 6'b010000,
        PH_BAD    = 6'b100000
    } t_phase;

    logic [7:0] r_end_tag, r_pad_tag, r_frame_tag, r_stamp_tag, r_tv_tag;

    t_phase      r_phase, n_phase;
    logic [15:0] r_count, n_count;
    logic [7:0]  r_version, n_version;
    logic [15:0] r_encap, n_encap;
    logic [7:0]  r_left, n_left;
    logic [7:0]  r_index, n_index;
    logic [15:0] r_frame, n_frame;
    logic [31:0] r_sec, n_sec;
    logic [31:0] r_usec, n_usec;
    logic [2:0]  r_found, n_found;
    logic [2:0]  r_sel, n_sel;
    logic [15:0] r_end_off, n_end_off;

    tzsp_pkg::t_result r_out, n_out;
    logic              r_out_valid;

    logic       in_acc;
    logic       out_acc;
    logic [7:0] d;

    assign d = i_in.data_byte;
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc = i_in.valid && i_in.ready;
    assign out_acc = r_out_valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_tag <= tzsp_pkg::RST_END_TAG;
            r_pad_tag <= tzsp_pkg::RST_PAD_TAG;
            r_frame_tag <= tzsp_pkg::RST_FRAME_LEN_TAG;
            r_stamp_tag <= tzsp_pkg::RST_STAMP32_TAG;
            r_tv_tag <= tzsp_pkg::RST_TIMEVAL_TAG;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tzsp_pkg::CFG_END_TAG: r_end_tag <= i_cfg_data;
                tzsp_pkg::CFG_PAD_TAG: r_pad_tag <= i_cfg_data;
                tzsp_pkg::CFG_FRAME_LEN_TAG: r_frame_tag <= i_cfg_data;
                tzsp_pkg::CFG_STAMP32_TAG: r_stamp_tag <= i_cfg_data;
                tzsp_pkg::CFG_TIMEVAL_TAG: r_tv_tag <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_version = r_version;
        n_encap = r_encap;
        n_left = r_left;
        n_index = r_index;
        n_frame = r_frame;
        n_sec = r_sec;
        n_usec = r_usec;
        n_found = r_found;
        n_sel = r_sel;
        n_end_off = r_end_off;
        n_count = (r_count < 16'(MAX_PACKET_BYTES)) ? r_count + 16'd1 : r_count;

        case (r_phase)
            PH_HEADER: begin
                if (r_count == 16'd0) begin
                    n_version = d;
                end else if (r_count == 16'd2) begin
                    n_encap = {d, 8'h00};
                end else if (r_count == 16'd3) begin
                    n_encap[7:0] = d;
                    n_phase = (r_version == tzsp_pkg::TZSP_VERSION) ? PH_TYPE : PH_BAD;
                end
            end
            PH_TYPE: begin
                if (d == r_end_tag) begin
                    n_end_off = (r_count != 16'hFFFF) ? r_count + 16'd1 : 16'hFFFF;
                    n_phase = PH_DONE;
                end else if (d != r_pad_tag) begin
                    n_sel = 3'b000;
                    if (d == r_frame_tag && !r_found[tzsp_pkg::FLAG_FRAME]) begin
                        n_found[tzsp_pkg::FLAG_FRAME] = 1'b1;
                        n_sel[tzsp_pkg::FLAG_FRAME] = 1'b1;
                        n_frame = 16'd0;
                    end
                    if (d == r_tv_tag && !r_found[tzsp_pkg::FLAG_TIMEVAL]) begin
                        n_found[tzsp_pkg::FLAG_TIMEVAL] = 1'b1;
                        n_sel[tzsp_pkg::FLAG_TIMEVAL] = 1'b1;
                        n_sec = 32'd0;
                        n_usec = 32'd0;
                    end
                    if (d == r_stamp_tag && !r_found[tzsp_pkg::FLAG_STAMP32]) begin
                        n_found[tzsp_pkg::FLAG_STAMP32] = 1'b1;
                        if (!n_found[tzsp_pkg::FLAG_TIMEVAL]) begin
                            n_sel[tzsp_pkg::FLAG_STAMP32] = 1'b1;
                            n_sec = 32'd0;
                        end
                    end
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                n_left = d;
                n_index = 8'd0;
                n_phase = (d != 8'd0) ? PH_VALUE : PH_TYPE;
            end
            PH_VALUE: begin
                if (r_sel[tzsp_pkg::FLAG_FRAME]) begin
                    case (r_index)
                        8'd0: n_frame[15:8] = d;
                        8'd1: n_frame[7:0] = d;
                        default: ;
                    endcase
                end
                if (r_sel[tzsp_pkg::FLAG_STAMP32]) begin
                    case (r_index)
                        8'd0: n_sec[31:24] = d;
                        8'd1: n_sec[23:16] = d;
                        8'd2: n_sec[15:8] = d;
                        8'd3: n_sec[7:0] = d;
                        default: ;
                    endcase
                end
                if (r_sel[tzsp_pkg::FLAG_TIMEVAL]) begin
                    case (r_index)
                        8'd4: n_sec[31:24] = d;
                        8'd5: n_sec[23:16] = d;
                        8'd6: n_sec[15:8] = d;
                        8'd7: n_sec[7:0] = d;
                        8'd12: n_usec[31:24] = d;
                        8'd13: n_usec[23:16] = d;
                        8'd14: n_usec[15:8] = d;
                        8'd15: n_usec[7:0] = d;
                        default: ;
                    endcase
                end
                n_index = r_index + 8'd1;
                n_left = r_left - 8'd1;
                if (r_left == 8'd1) begin
                    n_phase = PH_TYPE;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_out.status = tzsp_pkg::ST_OK;
        n_out.encap = 16'd0;
        n_out.wire_length = n_count;
        n_out.wire_len_tagged = 1'b0;
        n_out.stamp_kind = tzsp_pkg::SK_NONE;
        n_out.stamp_sec = 32'd0;
        n_out.stamp_usec = 32'd0;
        n_out.payload_offset = 16'd0;
        if (n_phase == PH_HEADER) begin
            n_out.status = tzsp_pkg::ST_SHORT;
        end else if (n_phase == PH_BAD) begin
            n_out.status = tzsp_pkg::ST_BAD_VER;
            n_out.encap = n_encap;
        end else begin
            n_out.status = (n_phase == PH_DONE) ? tzsp_pkg::ST_OK : tzsp_pkg::ST_NO_END;
            n_out.encap = n_encap;
            if (n_found[tzsp_pkg::FLAG_FRAME]) begin
                n_out.wire_length = n_frame;
                n_out.wire_len_tagged = 1'b1;
            end
            if (n_found[tzsp_pkg::FLAG_TIMEVAL]) begin
                n_out.stamp_kind = tzsp_pkg::SK_TIMEVAL;
                n_out.stamp_sec = n_sec;
                n_out.stamp_usec = n_usec;
            end else if (n_found[tzsp_pkg::FLAG_STAMP32]) begin
                n_out.stamp_kind = tzsp_pkg::SK_STAMP32;
                n_out.stamp_sec = n_sec;
            end
            if (n_phase == PH_DONE) begin
                n_out.payload_offset = n_end_off;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_acc && i_in.last)) begin
            r_phase <= PH_HEADER;
            r_count <= 16'd0;
            r_version <= 8'd0;
            r_encap <= 16'd0;
            r_left <= 8'd0;
            r_index <= 8'd0;
            r_frame <= 16'd0;
            r_sec <= 32'd0;
            r_usec <= 32'd0;
            r_found <= 3'b000;
            r_sel <= 3'b000;
            r_end_off <= 16'd0;
        end else if (in_acc) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_version <= n_version;
            r_encap <= n_encap;
            r_left <= n_left;
            r_index <= n_index;
            r_frame <= n_frame;
            r_sec <= n_sec;
            r_usec <= n_usec;
            r_found <= n_found;
            r_sel <= n_sel;
            r_end_off <= n_end_off;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && i_in.last) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.last) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.status = r_out.status;
    assign o_out.encap = r_out.encap;
    assign o_out.wire_length = r_out.wire_length;
    assign o_out.wire_len_tagged = r_out.wire_len_tagged;
    assign o_out.stamp_kind = r_out.stamp_kind;
    assign o_out.stamp_sec = r_out.stamp_sec;
    assign o_out.stamp_usec = r_out.stamp_usec;
    assign o_out.payload_offset = r_out.payload_offset;

    // A summary beat only ever follows an accepted last byte.
    `ASSERT_SAME(a_out_after_last, i_clk, i_rst_n, $rose(r_out_valid),
        $past(in_acc && i_in.last))

    // The parse state starts over after every packet.
    `ASSERT_NEXT(a_restart, i_clk, i_rst_n, in_acc && i_in.last,
        r_phase == PH_HEADER && r_count == 16'd0 && r_found == 3'b000)

    // Only a packet that reached its end tag reports a payload offset.
    `ASSERT_SAME(a_offset_ok_only, i_clk, i_rst_n,
        r_out_valid && r_out.status != tzsp_pkg::ST_OK, r_out.payload_offset == 16'd0)

endmodule

// ----- sim/tb_tzsp_tag_parser.sv -----
`timescale 1ns / 1ps

module tb_tzsp_tag_parser;

    localparam int unsigned RUN_LIMIT = 500000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned BYTES_PER_PHASE = 65;
    localparam int unsigned NUM_PHASES = 8;

    typedef enum logic [2:0] {
        WS_HEADER, WS_TYPE, WS_LEN, WS_VALUE, WS_DONE, WS_BAD
    } t_walk;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle;

    typedef struct {
        logic [7:0]        data_byte;
        logic              last;
        logic              typed;
        tzsp_pkg::t_result summary;
    } t_dir_row;

    localparam tzsp_pkg::t_result NO_SUM = '0;
    localparam tzsp_pkg::t_result SUM_SHORT =
        '{tzsp_pkg::ST_SHORT, 16'h0000, 16'd1, 1'b0, tzsp_pkg::SK_NONE,
          32'h0, 32'h0, 16'd0};
    localparam tzsp_pkg::t_result SUM_BAD_VER =
        '{tzsp_pkg::ST_BAD_VER, 16'hFFFF, 16'd4, 1'b0, tzsp_pkg::SK_NONE,
          32'h0, 32'h0, 16'd0};
    localparam tzsp_pkg::t_result SUM_FRAME =
        '{tzsp_pkg::ST_OK, 16'h1234, 16'hABCD, 1'b1, tzsp_pkg::SK_NONE,
          32'h0, 32'h0, 16'd9};

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [tzsp_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [tzsp_pkg::CFG_DATA_W-1:0] i_cfg_data;

    tzsp_in_if byte_ch ();
    tzsp_out_if sum_ch ();

    tzsp_tag_parser DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (byte_ch),
        .o_out      (sum_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Tag codes as the parser currently holds them.
    logic [7:0] code_end, code_pad, code_frame_len, code_stamp32, code_timeval;

    // Packet walk state of the predictor.
    t_walk       walk;
    logic [15:0] pkt_count;
    logic [7:0]  ver_byte;
    logic [15:0] encap_acc;
    logic [7:0]  val_left;
    logic [7:0]  val_index;
    logic [15:0] frame_len_acc;
    logic [31:0] sec_acc;
    logic [31:0] usec_acc;
    logic [2:0]  found;
    logic [2:0]  capture;
    logic [15:0] end_off;

    tzsp_pkg::t_result pending_summaries[$];
    logic [7:0]        pkt_bytes[$];
    t_idle             idle_mode = IDLE_NONE;
    int                mismatches = 0;
    int                cycle_count = 0;
    int                hold_req = 0;
    int                hold_taken = 0;
    int                hold_left = 0;

    t_dir_row directed_bytes [25] = '{
        '{8'h01, 1'b1, 1'b1, SUM_SHORT},
        '{8'h00, 1'b0, 1'b0, NO_SUM},
        '{8'h00, 1'b0, 1'b0, NO_SUM},
        '{8'hFF, 1'b0, 1'b0, NO_SUM},
        '{8'hFF, 1'b1, 1'b1, SUM_BAD_VER},
        '{8'h01, 1'b0, 1'b0, NO_SUM},
        '{8'h00, 1'b0, 1'b0, NO_SUM},
        '{8'h12, 1'b0, 1'b0, NO_SUM},
        '{8'h34, 1'b0, 1'b0, NO_SUM},
        '{8'h29, 1'b0, 1'b0, NO_SUM},
        '{8'h02, 1'b0, 1'b0, NO_SUM},
        '{8'hAB, 1'b0, 1'b0, NO_SUM},
        '{8'hCD, 1'b0, 1'b0, NO_SUM},
        '{8'h01, 1'b0, 1'b0, NO_SUM},
        '{8'h7E, 1'b1, 1'b1, SUM_FRAME},
        '{8'h01, 1'b0, 1'b0, NO_SUM},
        '{8'h00, 1'b0, 1'b0, NO_SUM},
        '{8'h00, 1'b0, 1'b0, NO_SUM},
        '{8'h01, 1'b0, 1'b0, NO_SUM},
        '{8'h00, 1'b0, 1'b0, NO_SUM},
        '{8'hFF, 1'b0, 1'b0, NO_SUM},
        '{8'h01, 1'b0, 1'b0, NO_SUM},
        '{8'h55, 1'b0, 1'b0, NO_SUM},
        '{8'h0D, 1'b0, 1'b0, NO_SUM},
        '{8'h00, 1'b1, 1'b0, NO_SUM}
    };

    function automatic void clear_walk();
        walk = WS_HEADER;
        pkt_count = '0;
        ver_byte = '0;
        encap_acc = '0;
        val_left = '0;
        val_index = '0;
        frame_len_acc = '0;
        sec_acc = '0;
        usec_acc = '0;
        found = '0;
        capture = '0;
        end_off = '0;
    endfunction

    function automatic void walk_tag_byte(input logic [7:0] d, input logic lst,
                                          output logic has_sum,
                                          output tzsp_pkg::t_result sum);
        logic [15:0] pos;
        int ix;
        pos = pkt_count;
        ix = val_index;
        has_sum = 1'b0;
        sum = NO_SUM;
        if (pkt_count < 16'(tzsp_pkg::MAX_PACKET_BYTES)) pkt_count = pkt_count + 16'd1;
        case (walk)
            WS_HEADER: begin
                if (pos == 16'd0) begin
                    ver_byte = d;
                end else if (pos == 16'd2) begin
                    encap_acc = {d, 8'h00};
                end else if (pos == 16'd3) begin
                    encap_acc[7:0] = d;
                    walk = (ver_byte == tzsp_pkg::TZSP_VERSION) ? WS_TYPE : WS_BAD;
                end
            end
            WS_TYPE: begin
                if (d == code_end) begin
                    end_off = (pos == 16'hFFFF) ? pos : pos + 16'd1;
                    walk = WS_DONE;
                end else if (d != code_pad) begin
                    capture = '0;
                    if (d == code_frame_len && !found[tzsp_pkg::FLAG_FRAME]) begin
                        found[tzsp_pkg::FLAG_FRAME] = 1'b1;
                        capture[tzsp_pkg::FLAG_FRAME] = 1'b1;
                        frame_len_acc = '0;
                    end
                    if (d == code_timeval && !found[tzsp_pkg::FLAG_TIMEVAL]) begin
                        found[tzsp_pkg::FLAG_TIMEVAL] = 1'b1;
                        capture[tzsp_pkg::FLAG_TIMEVAL] = 1'b1;
                        sec_acc = '0;
                        usec_acc = '0;
                    end
                    if (d == code_stamp32 && !found[tzsp_pkg::FLAG_STAMP32]) begin
                        found[tzsp_pkg::FLAG_STAMP32] = 1'b1;
                        if (!found[tzsp_pkg::FLAG_TIMEVAL]) begin
                            capture[tzsp_pkg::FLAG_STAMP32] = 1'b1;
                            sec_acc = '0;
                        end
                    end
                    walk = WS_LEN;
                end
            end
            WS_LEN: begin
                val_left = d;
                val_index = '0;
                walk = (d != 8'd0) ? WS_VALUE : WS_TYPE;
            end
            WS_VALUE: begin
                if (capture[tzsp_pkg::FLAG_FRAME] && ix < 2)
                    frame_len_acc[(1-ix)*8 +: 8] = frame_len_acc[(1-ix)*8 +: 8] | d;
                if (capture[tzsp_pkg::FLAG_STAMP32] && ix < 4)
                    sec_acc[(3-ix)*8 +: 8] = sec_acc[(3-ix)*8 +: 8] | d;
                if (capture[tzsp_pkg::FLAG_TIMEVAL]) begin
                    if (ix >= 4 && ix < 8)
                        sec_acc[(7-ix)*8 +: 8] = sec_acc[(7-ix)*8 +: 8] | d;
                    else if (ix >= 12 && ix < 16)
                        usec_acc[(15-ix)*8 +: 8] = usec_acc[(15-ix)*8 +: 8] | d;
                end
                val_index = val_index + 8'd1;
                val_left = val_left - 8'd1;
                if (val_left == 8'd0) walk = WS_TYPE;
            end
            default: begin
            end
        endcase

        if (lst) begin
            has_sum = 1'b1;
            sum.wire_length = pkt_count;
            if (walk == WS_HEADER) begin
                sum.status = tzsp_pkg::ST_SHORT;
            end else if (walk == WS_BAD) begin
                sum.status = tzsp_pkg::ST_BAD_VER;
                sum.encap = encap_acc;
            end else begin
                sum.status = (walk == WS_DONE) ? tzsp_pkg::ST_OK : tzsp_pkg::ST_NO_END;
                sum.encap = encap_acc;
                if (found[tzsp_pkg::FLAG_FRAME]) begin
                    sum.wire_length = frame_len_acc;
                    sum.wire_len_tagged = 1'b1;
                end
                if (found[tzsp_pkg::FLAG_TIMEVAL]) begin
                    sum.stamp_kind = tzsp_pkg::SK_TIMEVAL;
                    sum.stamp_sec = sec_acc;
                    sum.stamp_usec = usec_acc;
                end else if (found[tzsp_pkg::FLAG_STAMP32]) begin
                    sum.stamp_kind = tzsp_pkg::SK_STAMP32;
                    sum.stamp_sec = sec_acc;
                end
                if (walk == WS_DONE) sum.payload_offset = end_off;
            end
            clear_walk();
        end
    endfunction

    function automatic void cmp_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_byte(input logic [7:0] d, input logic lst, input logic typed,
                             input tzsp_pkg::t_result typed_sum);
        logic has_sum;
        tzsp_pkg::t_result sum;
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SEND) ? 54 : (idle_mode == IDLE_BOTH) ? 26 : 0;
        while ($urandom_range(0, 99) < gap_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= d;
        byte_ch.last <= lst;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        walk_tag_byte(d, lst, has_sum, sum);
        if (has_sum) pending_summaries.push_back(typed ? typed_sum : sum);
    endtask

    task automatic send_packet();
        foreach (pkt_bytes[k])
            send_byte(pkt_bytes[k], k == pkt_bytes.size() - 1, 1'b0, NO_SUM);
    endtask

    task automatic settle();
        byte_ch.valid <= 1'b0;
        while (pending_summaries.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_code(input logic [tzsp_pkg::CFG_IDX_W-1:0] idx,
                              input logic [7:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        case (idx)
            tzsp_pkg::CFG_END_TAG:       code_end = v;
            tzsp_pkg::CFG_PAD_TAG:       code_pad = v;
            tzsp_pkg::CFG_FRAME_LEN_TAG: code_frame_len = v;
            tzsp_pkg::CFG_STAMP32_TAG:   code_stamp32 = v;
            tzsp_pkg::CFG_TIMEVAL_TAG:   code_timeval = v;
            default: begin
            end
        endcase
    endtask

    task automatic load_codes(input logic [7:0] e, input logic [7:0] p, input logic [7:0] f,
                              input logic [7:0] s, input logic [7:0] t);
        write_code(tzsp_pkg::CFG_END_TAG, e);
        write_code(tzsp_pkg::CFG_PAD_TAG, p);
        write_code(tzsp_pkg::CFG_FRAME_LEN_TAG, f);
        write_code(tzsp_pkg::CFG_STAMP32_TAG, s);
        write_code(tzsp_pkg::CFG_TIMEVAL_TAG, t);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly well-formed packets with random tag content; some short headers,
    // bad versions, stray tag types and packets cut off mid-walk.
    task automatic build_packet();
        int roll;
        int len;
        logic [7:0] tag;
        pkt_bytes.delete();
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            repeat ($urandom_range(1, 3)) pkt_bytes.push_back(8'($urandom));
        end else if (roll < 16) begin
            tag = 8'($urandom);
            pkt_bytes.push_back((tag == tzsp_pkg::TZSP_VERSION) ? 8'hFF : tag);
            repeat ($urandom_range(3, 8)) pkt_bytes.push_back(8'($urandom));
        end else begin
            pkt_bytes.push_back(tzsp_pkg::TZSP_VERSION);
            repeat (3) pkt_bytes.push_back(8'($urandom));
            repeat ($urandom_range(0, 6)) begin
                len = -1;
                case ($urandom_range(0, 9))
                    0, 1: tag = code_pad;
                    2, 3: begin
                        tag = code_frame_len;
                        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 2;
                    end
                    4, 5: begin
                        tag = code_stamp32;
                        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 4;
                    end
                    6, 7: begin
                        tag = code_timeval;
                        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : 16;
                    end
                    8: begin
                        tag = 8'($urandom);
                        len = $urandom_range(0, 6);
                    end
                    default: begin
                        tag = 8'($urandom);
                        len = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 40);
                    end
                endcase
                pkt_bytes.push_back(tag);
                if (len >= 0) begin
                    pkt_bytes.push_back(8'(len));
                    repeat (len) pkt_bytes.push_back(8'($urandom));
                end
            end
            if ($urandom_range(0, 99) < 85) begin
                pkt_bytes.push_back(code_end);
                repeat ($urandom_range(0, 3)) pkt_bytes.push_back(8'($urandom));
            end else if ($urandom_range(0, 1) == 1) begin
                while (pkt_bytes.size() > 1 && $urandom_range(0, 3) != 0)
                    void'(pkt_bytes.pop_back());
            end
        end
    endtask

    always @(posedge i_clk) begin : summary_sink
        tzsp_pkg::t_result want;
        int stall_pct;
        if (!i_rst_n) begin
            sum_ch.ready <= 1'b0;
        end else begin
            if (sum_ch.valid && sum_ch.ready) begin
                if (pending_summaries.size() == 0) begin
                    $display("%0t: summary beat with none expected, got status %0h",
                             $time, sum_ch.status);
                    mismatches++;
                end else begin
                    want = pending_summaries.pop_front();
                    cmp_field("status", 32'(want.status), 32'(sum_ch.status));
                    cmp_field("encap", 32'(want.encap), 32'(sum_ch.encap));
                    cmp_field("wire_length", 32'(want.wire_length),
                              32'(sum_ch.wire_length));
                    cmp_field("wire_len_tagged", 32'(want.wire_len_tagged),
                              32'(sum_ch.wire_len_tagged));
                    cmp_field("stamp_kind", 32'(want.stamp_kind), 32'(sum_ch.stamp_kind));
                    cmp_field("stamp_sec", want.stamp_sec, sum_ch.stamp_sec);
                    cmp_field("stamp_usec", want.stamp_usec, sum_ch.stamp_usec);
                    cmp_field("payload_offset", 32'(want.payload_offset),
                              32'(sum_ch.payload_offset));
                end
            end
            stall_pct = (idle_mode == IDLE_RECV) ? 54 : (idle_mode == IDLE_BOTH) ? 26 : 0;
            if (hold_taken != hold_req) begin
                hold_taken = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                sum_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                sum_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int sent;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        byte_ch.valid = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.last = 1'b0;
        code_end = tzsp_pkg::RST_END_TAG;
        code_pad = tzsp_pkg::RST_PAD_TAG;
        code_frame_len = tzsp_pkg::RST_FRAME_LEN_TAG;
        code_stamp32 = tzsp_pkg::RST_STAMP32_TAG;
        code_timeval = tzsp_pkg::RST_TIMEVAL_TAG;
        clear_walk();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_bytes[k])
            send_byte(directed_bytes[k].data_byte, directed_bytes[k].last,
                      directed_bytes[k].typed, directed_bytes[k].summary);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            case (ph)
                0: load_codes(8'h00, 8'hFF, 8'h01, 8'h02, 8'h03);
                1: load_codes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
                2: load_codes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
                3: load_codes(tzsp_pkg::RST_END_TAG, tzsp_pkg::RST_PAD_TAG,
                              tzsp_pkg::RST_FRAME_LEN_TAG, tzsp_pkg::RST_STAMP32_TAG,
                              tzsp_pkg::RST_TIMEVAL_TAG);
                5: begin
                    code_timeval = 8'($urandom);
                    load_codes(8'($urandom), 8'($urandom), 8'($urandom),
                               code_timeval, code_timeval);
                end
                default: load_codes(8'($urandom), 8'($urandom), 8'($urandom),
                                    8'($urandom), 8'($urandom));
            endcase
            idle_mode = t_idle'(ph % 4);
            if (ph == 4) hold_req++;
            sent = 0;
            while (sent < BYTES_PER_PHASE) begin
                build_packet();
                sent += pkt_bytes.size();
                send_packet();
            end
        end

        settle();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
